// ===== design/trrsa_pkg.sv =====
// ----------------------------------------------------------------------------
// trrsa_pkg: shared definitions for the timed round-robin send arbiter
// Field widths, configuration register indexes and reset values, and the
// write command that the sequencer hands to the per-stream table.
// ----------------------------------------------------------------------------
`default_nettype none

package trrsa_pkg;

    localparam int NUM_STREAMS_DEF = 4;
    localparam int DATA_BITS       = 4;
    localparam int TICK_W          = 32;
    localparam int HOLD_W          = 16;
    localparam int CNT_W           = 32;
    localparam int SEL_W           = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SEND_HOLDOFF  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_HOLDOFF = 1'd1;

    localparam logic [HOLD_W-1:0] SEND_HOLDOFF_RST  = 16'd3;
    localparam logic [HOLD_W-1:0] RETRY_HOLDOFF_RST = 16'd10;

    // Write command for the per-stream table; the entry is chosen by a
    // separate index port.
    typedef struct packed {
        logic              hold_we;
        logic              att_inc;
        logic [TICK_W-1:0] hold_val;
    } tbl_wr_t;

endpackage

`default_nettype wire

// ===== design/trrsa_in_if.sv =====
// ----------------------------------------------------------------------------
// trrsa_in_if: request channel of the send arbiter
// Valid/ready channel carrying one request or confirm beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface trrsa_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [trrsa_pkg::TICK_W-1:0] now_ticks;
    logic [trrsa_pkg::DATA_BITS-1:0] data_mask;
    logic                         send_failed;

    modport source (output valid, op, now_ticks, data_mask, send_failed, input ready);
    modport sink   (input valid, op, now_ticks, data_mask, send_failed, output ready);
endinterface

`default_nettype wire

// ===== design/trrsa_out_if.sv =====
// ----------------------------------------------------------------------------
// trrsa_out_if: result channel of the send arbiter
// Valid/ready channel carrying one result beat per request or confirm.
// ----------------------------------------------------------------------------
`default_nettype none

interface trrsa_out_if;
    logic                        valid;
    logic                        ready;
    logic                        granted;
    logic [trrsa_pkg::SEL_W-1:0] stream_sel;
    logic                        locked_out;
    logic                        stray_confirm;
    logic [trrsa_pkg::CNT_W-1:0] attempts_of_stream;
    logic [trrsa_pkg::CNT_W-1:0] total_sent;
    logic [trrsa_pkg::CNT_W-1:0] ok_total;
    logic [trrsa_pkg::CNT_W-1:0] fail_total;
    logic [trrsa_pkg::CNT_W-1:0] outcome_history;

    modport source (output valid, granted, stream_sel, locked_out, stray_confirm,
                    attempts_of_stream, total_sent, ok_total, fail_total,
                    outcome_history, input ready);
    modport sink   (input valid, granted, stream_sel, locked_out, stray_confirm,
                    attempts_of_stream, total_sent, ok_total, fail_total,
                    outcome_history, output ready);
endinterface

`default_nettype wire

// ===== design/trrsa_stream_table.sv =====
// ----------------------------------------------------------------------------
// trrsa_stream_table: per-stream holdoff deadlines and attempt counters
// One entry per stream, read and written at the single index that the
// sequencer drives.
// ----------------------------------------------------------------------------
`default_nettype none

module trrsa_stream_table #(
    parameter int NUM_STREAMS = trrsa_pkg::NUM_STREAMS_DEF,
    parameter int SW          = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [SW-1:0]                idx,
    input  wire trrsa_pkg::tbl_wr_t           wr,
    output logic      [trrsa_pkg::TICK_W-1:0] hold_rd,
    output logic      [trrsa_pkg::CNT_W-1:0]  att_rd
);

    logic [trrsa_pkg::TICK_W-1:0] holdoff_reg [NUM_STREAMS];
    logic [trrsa_pkg::CNT_W-1:0]  attempt_reg [NUM_STREAMS];

    assign hold_rd = holdoff_reg[idx];
    assign att_rd  = attempt_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                holdoff_reg[i] <= '0;
                attempt_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.hold_we)
            begin
                holdoff_reg[idx] <= wr.hold_val;
            end
            if (wr.att_inc)
            begin
                attempt_reg[idx] <= attempt_reg[idx] + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/timed_round_robin_send_arbiter.sv =====
// ----------------------------------------------------------------------------
// timed_round_robin_send_arbiter: round-robin send arbiter with holdoff
// Picks the next transmit stream that has data and whose holdoff deadline
// has passed, keeps one send outstanding until it is confirmed, and keeps
// grant, success and failure statistics.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (op = 0) on req_ch asks for a stream to send; it carries the
// current tick count and a mask of streams holding data. A confirm beat
// (op = 1) closes the outstanding send and reports whether it failed. Every
// beat yields exactly one result beat on res_ch.
// The two holdoff registers are written through cfg_we / cfg_index / cfg_data
// and should only be changed while the arbiter is idle.
// Timing: req_ch.ready is high only while the sequencer is idle. After a beat
// is accepted the sequencer works one stream per cycle while the result
// register is free, through a single compare and add unit: a confirm or a
// refused request takes one step, a scan takes one to NUM_STREAMS steps.
// The result appears registered on the cycle after the last step, and the
// input channel takes no new beat until that last step is done.
// The result register lets the next beat be accepted while a result waits.
// If res_ch stalls with a result still held, the first step of the next item
// waits until the result register frees up, so nothing is lost or reordered.
// Reset clears all counters, deadlines and the pending send, restores the
// holdoff registers to 3 and 10 ticks, and makes stream 0 the first scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_round_robin_send_arbiter #(
    parameter int NUM_STREAMS = trrsa_pkg::NUM_STREAMS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [trrsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trrsa_pkg::CFG_DATA_W-1:0] cfg_data,
    trrsa_in_if.sink                              req_ch,
    trrsa_out_if.source                           res_ch
);

    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_STREAMS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_STEP = 1'b1;

    typedef struct packed {
        logic                        granted;
        logic [trrsa_pkg::SEL_W-1:0] stream_sel;
        logic                        locked_out;
        logic                        stray_confirm;
        logic [trrsa_pkg::CNT_W-1:0] attempts_of_stream;
        logic [trrsa_pkg::CNT_W-1:0] total_sent;
        logic [trrsa_pkg::CNT_W-1:0] ok_total;
        logic [trrsa_pkg::CNT_W-1:0] fail_total;
        logic [trrsa_pkg::CNT_W-1:0] outcome_history;
    } result_t;

    // Sequencer and captured beat.
    logic                            state_reg, state_next;
    logic                            op_reg;
    logic [trrsa_pkg::TICK_W-1:0]    now_reg;
    logic [trrsa_pkg::DATA_BITS-1:0] mask_reg;
    logic                            failed_reg;
    logic [SW-1:0]                   idx_reg, idx_next;
    logic [SW-1:0]                   cnt_reg, cnt_next;

    // Arbiter state.
    logic                            pending_valid_reg, pending_valid_next;
    logic [SW-1:0]                   pending_stream_reg, pending_stream_next;
    logic [SW-1:0]                   last_served_reg, last_served_next;
    logic [trrsa_pkg::CNT_W-1:0]     grant_count_reg, grant_count_next;
    logic [trrsa_pkg::CNT_W-1:0]     success_count_reg, success_count_next;
    logic [trrsa_pkg::CNT_W-1:0]     failure_count_reg, failure_count_next;
    logic [trrsa_pkg::CNT_W-1:0]     history_reg, history_next;
    logic [trrsa_pkg::HOLD_W-1:0]    send_holdoff_reg;
    logic [trrsa_pkg::HOLD_W-1:0]    retry_holdoff_reg;

    // Result register.
    result_t                         res_reg, res_next;
    logic                            res_valid_reg, res_valid_next;

    // Table interface.
    trrsa_pkg::tbl_wr_t              tbl_wr;
    logic [trrsa_pkg::TICK_W-1:0]    hold_rd;
    logic [trrsa_pkg::CNT_W-1:0]     att_rd;

    logic                            in_fire;
    logic                            slot_free;
    logic                            step_fire;
    logic                            step_last;
    logic                            eligible;
    logic                            grant_hit;
    logic                            conf_ok;
    logic [NUM_STREAMS-1:0]          data_vec;
    logic [trrsa_pkg::TICK_W-1:0]    deadline_sum;

    trrsa_stream_table #(
        .NUM_STREAMS (NUM_STREAMS),
        .SW          (SW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (idx_reg),
        .wr      (tbl_wr),
        .hold_rd (hold_rd),
        .att_rd  (att_rd)
    );

    // Streams beyond the mask width never have data.
    for (genvar g = 0; g < NUM_STREAMS; g++)
    begin : g_data
        if (g < trrsa_pkg::DATA_BITS)
        begin : g_bit
            assign data_vec[g] = mask_reg[g];
        end
        else
        begin : g_none
            assign data_vec[g] = 1'b0;
        end
    end

    assign req_ch.ready = (state_reg == ST_IDLE);
    assign in_fire      = req_ch.valid && req_ch.ready;

    assign slot_free = !res_valid_reg || res_ch.ready;
    assign step_fire = (state_reg == ST_STEP) && slot_free;

    // The shared unit: one deadline compare and one deadline add per step.
    assign eligible  = (hold_rd < now_reg) && data_vec[idx_reg];
    assign deadline_sum = now_reg + {{(trrsa_pkg::TICK_W - trrsa_pkg::HOLD_W){1'b0}},
                                     (op_reg && failed_reg) ? retry_holdoff_reg
                                                            : send_holdoff_reg};

    assign grant_hit = !op_reg && !pending_valid_reg && eligible;
    assign conf_ok   = op_reg && pending_valid_reg;
    assign step_last = op_reg || pending_valid_reg || eligible || (cnt_reg == LAST_IDX);

    always_comb
    begin
        tbl_wr.hold_we  = step_fire && (grant_hit || conf_ok);
        tbl_wr.att_inc  = step_fire && grant_hit;
        tbl_wr.hold_val = deadline_sum;
    end

    always_comb
    begin
        state_next          = state_reg;
        idx_next            = idx_reg;
        cnt_next            = cnt_reg;
        pending_valid_next  = pending_valid_reg;
        pending_stream_next = pending_stream_reg;
        last_served_next    = last_served_reg;
        grant_count_next    = grant_count_reg;
        success_count_next  = success_count_reg;
        failure_count_next  = failure_count_reg;
        history_next        = history_reg;
        res_next            = res_reg;
        res_valid_next      = res_valid_reg && !res_ch.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_STEP;
                    cnt_next   = '0;
                    // A refused request or a confirm looks at the pending stream;
                    // a scan starts after the stream served last.
                    if (pending_valid_reg)
                    begin
                        idx_next = pending_stream_reg;
                    end
                    else
                    begin
                        idx_next = (last_served_reg == LAST_IDX) ? '0
                                                                 : last_served_reg + 1'b1;
                    end
                end
            end
            ST_STEP:
            begin
                if (step_fire)
                begin
                    if (grant_hit)
                    begin
                        pending_valid_next  = 1'b1;
                        pending_stream_next = idx_reg;
                        last_served_next    = idx_reg;
                        grant_count_next    = grant_count_reg + 1'b1;
                    end
                    else if (conf_ok)
                    begin
                        pending_valid_next = 1'b0;
                        if (failed_reg)
                        begin
                            failure_count_next = failure_count_reg + 1'b1;
                            history_next       = {history_reg[trrsa_pkg::CNT_W-2:0], 1'b0};
                        end
                        else
                        begin
                            success_count_next = success_count_reg + 1'b1;
                            history_next       = {history_reg[trrsa_pkg::CNT_W-2:0], 1'b1};
                        end
                    end

                    if (step_last)
                    begin
                        state_next                  = ST_IDLE;
                        res_valid_next              = 1'b1;
                        res_next.granted            = grant_hit;
                        res_next.locked_out         = !op_reg && pending_valid_reg;
                        res_next.stray_confirm      = op_reg && !pending_valid_reg;
                        res_next.total_sent         = grant_count_next;
                        res_next.ok_total           = success_count_next;
                        res_next.fail_total         = failure_count_next;
                        res_next.outcome_history    = history_next;
                        if (pending_valid_reg || grant_hit)
                        begin
                            res_next.stream_sel         = trrsa_pkg::SEL_W'(idx_reg);
                            res_next.attempts_of_stream = grant_hit ? att_rd + 1'b1 : att_rd;
                        end
                        else
                        begin
                            res_next.stream_sel         = '0;
                            res_next.attempts_of_stream = '0;
                        end
                    end
                    else
                    begin
                        idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            idx_reg            <= '0;
            cnt_reg            <= '0;
            pending_valid_reg  <= 1'b0;
            pending_stream_reg <= '0;
            last_served_reg    <= LAST_IDX;
            grant_count_reg    <= '0;
            success_count_reg  <= '0;
            failure_count_reg  <= '0;
            history_reg        <= '0;
            send_holdoff_reg   <= trrsa_pkg::SEND_HOLDOFF_RST;
            retry_holdoff_reg  <= trrsa_pkg::RETRY_HOLDOFF_RST;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            idx_reg            <= idx_next;
            cnt_reg            <= cnt_next;
            pending_valid_reg  <= pending_valid_next;
            pending_stream_reg <= pending_stream_next;
            last_served_reg    <= last_served_next;
            grant_count_reg    <= grant_count_next;
            success_count_reg  <= success_count_next;
            failure_count_reg  <= failure_count_next;
            history_reg        <= history_next;
            res_valid_reg      <= res_valid_next;
            if (cfg_we && (cfg_index == trrsa_pkg::REG_SEND_HOLDOFF))
            begin
                send_holdoff_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == trrsa_pkg::REG_RETRY_HOLDOFF))
            begin
                retry_holdoff_reg <= cfg_data;
            end
        end
    end

    // Captured beat and result payload need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= req_ch.op;
            now_reg    <= req_ch.now_ticks;
            mask_reg   <= req_ch.data_mask;
            failed_reg <= req_ch.send_failed;
        end
        res_reg <= res_next;
    end

    assign res_ch.valid              = res_valid_reg;
    assign res_ch.granted            = res_reg.granted;
    assign res_ch.stream_sel         = res_reg.stream_sel;
    assign res_ch.locked_out         = res_reg.locked_out;
    assign res_ch.stray_confirm      = res_reg.stray_confirm;
    assign res_ch.attempts_of_stream = res_reg.attempts_of_stream;
    assign res_ch.total_sent         = res_reg.total_sent;
    assign res_ch.ok_total           = res_reg.ok_total;
    assign res_ch.fail_total         = res_reg.fail_total;
    assign res_ch.outcome_history    = res_reg.outcome_history;

    // A grant locks the arbiter onto the stream that was scanned.
    a_grant_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && grant_hit) |=>
            (pending_valid_reg && (pending_stream_reg == $past(idx_reg))))
        else $error("grant did not lock onto the scanned stream");

    // A valid confirm always releases the lock.
    a_confirm_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && conf_ok) |=> !pending_valid_reg)
        else $error("confirm left the arbiter locked");

    // At most one of the outcome flags is set on a result beat.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $onehot0({res_reg.granted, res_reg.locked_out,
                                    res_reg.stray_confirm}))
        else $error("conflicting outcome flags on a result");

    // The scan never visits more streams than exist.
    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_IDX)
        else $error("scan counter ran past the last stream");

endmodule

`default_nettype wire
